// File: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// File: rtl/rwat_pkg.sv
package rwat_pkg;

   localparam int WINDOW_DEF = 64;
   localparam int HEIGHT_DEF = 64;
   localparam int AXES       = 3;
   localparam int SAMPLE_W   = 16;
   localparam int COLUMN_W   = 6;
   localparam int ROW_W      = 7;

   typedef struct packed {
      logic [1:0]          axis_select;
      logic signed [15:0]  sample;
   } req_type;

   typedef struct packed {
      logic [5:0] column;
      logic [6:0] y_left;
      logic [6:0] y_right;
      logic       last_segment;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RANGE,
      ST_READ,
      ST_LOAD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

endpackage

// File: rtl/rolling_window_autoscale_trace_top.sv
// Each run first scans the window for its minimum and maximum, then the bit-serial row divider
// computes the row of the first entry and then the row for each segment.
// Throughput: one sample per full run; req_ready is high only between runs, so no new sample is
// taken before the last segment is loaded. An axis 3 sample is accepted but produces no transfer.
// Reset (synchronous) clears the state, fill counts, write pointers and output valid flag;
// the sample memory is not cleared and needs no sweep.
`include "assert_macros.svh"

module rolling_window_autoscale_trace_top #(
   parameter int WINDOW = rwat_pkg::WINDOW_DEF,
   parameter int HEIGHT = rwat_pkg::HEIGHT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rwat_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rwat_pkg::rsp_type rsp_data
);

   localparam int AXES  = rwat_pkg::AXES;
   localparam int DW    = rwat_pkg::SAMPLE_W;
   localparam int COL_W = rwat_pkg::COLUMN_W;
   localparam int ROW_W = rwat_pkg::ROW_W;
   localparam int KW    = $clog2(WINDOW);
   localparam int CW    = $clog2(WINDOW + 1);
   localparam int DEPTH = AXES * WINDOW;
   localparam int AW    = $clog2(DEPTH);
   localparam int QW    = $clog2(HEIGHT + 1);
   localparam int NW    = DW + QW;

   rwat_pkg::state_type state_ff, state_in;

   logic [1:0]           ax_ff, ax_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [KW-1:0]        wptr_ff [AXES];
   logic [CW-1:0]        count_ff [AXES];
   logic [KW-1:0]        wptr_sel, wptr_in;
   logic [CW-1:0]        count_sel, count_in;
   logic [KW-1:0]        cur_wptr;
   logic [CW-1:0]        cur_count;

   logic [DW-1:0]        sample_mem [DEPTH];
   logic [DW-1:0]        rd_data_ff;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 rd_ok_ff;
   logic                 rd_en, store_we;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [KW:0]          phys_sum;
   logic [KW-1:0]        phys;
   logic signed [DW-1:0] rd_val;

   logic signed [DW-1:0] hi_ff, hi_in, lo_ff, lo_in;
   logic                 any_ff, any_in;
   logic [DW-1:0]        range_ff, range_in;
   logic [DW-1:0]        diff;
   logic [NW-1:0]        num_ff, num_in;
   logic [QW-1:0]        y_prev_ff, y_prev_in;
   logic                 entry_ok, pair_ok;

   logic                     div_start;
   logic [QW-1:0]            div_q;
   rwat_pkg::div_status_type div_stat;

   logic                 rsp_valid_ff, rsp_load;
   rwat_pkg::rsp_type    rsp_ff, rsp_in;

   assign req_ready = (state_ff == rwat_pkg::ST_IDLE);

   assign wptr_sel  = wptr_ff[req_data.axis_select];
   assign count_sel = count_ff[req_data.axis_select];
   assign wptr_in   = (wptr_sel == KW'(WINDOW - 1)) ? '0 : wptr_sel + 1'b1;
   assign count_in  = (count_sel == CW'(WINDOW)) ? count_sel : count_sel + 1'b1;

   assign cur_wptr  = wptr_ff[ax_ff];
   assign cur_count = count_ff[ax_ff];

   assign entry_ok = ({1'b0, k_ff} + {1'b0, cur_count}) >= (CW + 1)'(WINDOW);
   assign pair_ok  = ({1'b0, k_ff} + {1'b0, cur_count}) > (CW + 1)'(WINDOW);

   assign phys_sum = {1'b0, cur_wptr} + {1'b0, k_ff[KW-1:0]};
   assign phys     = (phys_sum >= (KW + 1)'(WINDOW)) ?
                     KW'(phys_sum - (KW + 1)'(WINDOW)) : phys_sum[KW-1:0];
   assign rd_addr  = AW'(AW'(ax_ff) * AW'(WINDOW)) + AW'(phys);
   assign wr_addr  = AW'(AW'(req_data.axis_select) * AW'(WINDOW)) + AW'(wptr_sel);

   assign rd_val = $signed(rd_data_ff);
   assign diff   = $unsigned(hi_ff - rd_val);

   always_comb begin
      state_in  = state_ff;
      ax_in     = ax_ff;
      k_in      = k_ff;
      store_we  = 1'b0;
      rd_en     = 1'b0;
      rd_vld_in = 1'b0;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      any_in    = any_ff;
      range_in  = range_ff;
      num_in    = num_ff;
      y_prev_in = y_prev_ff;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         rwat_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (32'(req_data.axis_select) < AXES) begin
                  ax_in    = req_data.axis_select;
                  store_we = 1'b1;
                  k_in     = '0;
                  any_in   = 1'b0;
                  state_in = rwat_pkg::ST_SCAN;
               end
            end
         end
         rwat_pkg::ST_SCAN: begin
            if (k_ff != CW'(WINDOW)) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               k_in      = k_ff + 1'b1;
            end
            if (rd_vld_ff && rd_ok_ff) begin
               if (!any_ff || rd_val > hi_ff) begin
                  hi_in = rd_val;
               end
               if (!any_ff || rd_val < lo_ff) begin
                  lo_in = rd_val;
               end
               any_in = 1'b1;
            end
            if (k_ff == CW'(WINDOW) && !rd_vld_ff) begin
               state_in = rwat_pkg::ST_RANGE;
            end
         end
         rwat_pkg::ST_RANGE: begin
            range_in = $unsigned(hi_ff - lo_ff);
            k_in     = '0;
            state_in = rwat_pkg::ST_READ;
         end
         rwat_pkg::ST_READ: begin
            rd_en    = 1'b1;
            state_in = rwat_pkg::ST_LOAD;
         end
         rwat_pkg::ST_LOAD: begin
            num_in   = NW'(NW'(HEIGHT) * NW'(diff));
            state_in = rwat_pkg::ST_DIV_START;
         end
         rwat_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = rwat_pkg::ST_DIV_WAIT;
         end
         rwat_pkg::ST_DIV_WAIT: begin
            if (div_stat.done) begin
               if (k_ff == '0) begin
                  y_prev_in = div_q;
                  k_in      = k_ff + 1'b1;
                  state_in  = rwat_pkg::ST_READ;
               end else begin
                  state_in  = rwat_pkg::ST_EMIT;
               end
            end
         end
         rwat_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load  = 1'b1;
               y_prev_in = div_q;
               if (k_ff == CW'(WINDOW - 1)) begin
                  state_in = rwat_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = rwat_pkg::ST_READ;
               end
            end
         end
      endcase
   end

   always_comb begin
      rsp_in.column       = COL_W'(k_ff - 1'b1);
      rsp_in.last_segment = (k_ff == CW'(WINDOW - 1));
      if (pair_ok && range_ff != '0) begin
         rsp_in.y_left  = ROW_W'(y_prev_ff);
         rsp_in.y_right = ROW_W'(div_q);
      end else begin
         rsp_in.y_left  = ROW_W'(HEIGHT);
         rsp_in.y_right = ROW_W'(HEIGHT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rwat_pkg::ST_IDLE;
         ax_ff        <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < AXES; a++) begin
            wptr_ff[a]  <= '0;
            count_ff[a] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         ax_ff     <= ax_in;
         rd_vld_ff <= rd_vld_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (store_we) begin
            wptr_ff[req_data.axis_select]  <= wptr_in;
            count_ff[req_data.axis_select] <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      rd_ok_ff  <= entry_ok;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      any_ff    <= any_in;
      range_ff  <= range_in;
      num_ff    <= num_in;
      y_prev_ff <= y_prev_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         sample_mem[wr_addr] <= req_data.sample;
      end
      if (rd_en) begin
         rd_data_ff <= sample_mem[rd_addr];
      end
   end

   rwat_divider #(
      .NUM_W(NW),
      .DEN_W(DW),
      .QUO_W(QW)
   ) u_rwat_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num_ff),
      .denominator (range_ff),
      .quotient    (div_q),
      .status      (div_stat)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_PROP(a_range_has_sample, clock, reset, state_ff == rwat_pkg::ST_RANGE |-> any_ff, "scan found no valid entry")
   `ASSERT_PROP(a_last_column, clock, reset, rsp_valid_ff && rsp_ff.last_segment |-> rsp_ff.column == COL_W'(WINDOW - 2), "last segment at wrong column")
   `ASSERT_NEVER(a_div_restart, clock, reset, div_start && div_stat.busy, "divider started while busy")
   `ASSERT_NEVER(a_fill_bound, clock, reset, count_ff[ax_ff] > CW'(WINDOW), "fill count beyond window")

endmodule

// File: rtl/rwat_divider.sv
module rwat_divider #(
   parameter int NUM_W = 23,
   parameter int DEN_W = 16,
   parameter int QUO_W = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [NUM_W-1:0]         numerator,
   input  logic [DEN_W-1:0]         denominator,
   output logic [QUO_W-1:0]         quotient,
   output rwat_pkg::div_status_type status
);

   localparam int SW = (QUO_W > 1) ? $clog2(QUO_W) : 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] q_ff, q_in;
   logic [SW-1:0]    step_ff, step_in;
   logic [NUM_W-1:0] trial;

   assign trial = NUM_W'(den_ff) << step_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      step_in = step_ff;
      priority if (start) begin
         busy_in = 1'b1;
         rem_in  = numerator;
         den_in  = denominator;
         step_in = SW'(QUO_W - 1);
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            q_in   = {q_ff[QUO_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QUO_W-2:0], 1'b0};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end else begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   assign quotient    = q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: tb/rolling_window_autoscale_trace_top_test.sv
module rolling_window_autoscale_trace_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW      = rwat_pkg::WINDOW_DEF;
   localparam int HEIGHT      = rwat_pkg::HEIGHT_DEF;
   localparam int AXES        = rwat_pkg::AXES;
   localparam int SAMPLE_W    = rwat_pkg::SAMPLE_W;
   localparam int COLUMN_W    = rwat_pkg::COLUMN_W;
   localparam int ROW_W       = rwat_pkg::ROW_W;
   localparam int TAIL_CYCLES = 1000;
   localparam int HOLD_CYCLES = 3000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid;
   logic              req_ready;
   rwat_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rwat_pkg::rsp_type rsp_data;

   logic drain_ready;
   logic hold_active;
   int   hold_len    = 0;
   bit   no_idle     = 1'b0;
   int   error_count = 0;

   logic signed [SAMPLE_W-1:0] trace_store [AXES][WINDOW];
   bit                         trace_live  [AXES][WINDOW];
   rwat_pkg::rsp_type          expected_segments [$];

   assign rsp_ready = drain_ready && !hold_active;

   rolling_window_autoscale_trace_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [ROW_W-1:0] scaled_row(input int v, input int hi,
                                                   input int unsigned span);
      int unsigned q;
      q = (HEIGHT * int'(hi - v)) / span;
      return q[ROW_W-1:0];
   endfunction

   function automatic void predict_segments(input rwat_pkg::req_type item);
      int                ax;
      int                hi;
      int                lo;
      int unsigned       span;
      bit                seen;
      rwat_pkg::rsp_type seg;
      ax   = int'(item.axis_select);
      hi   = 0;
      lo   = 0;
      seen = 1'b0;
      if (ax >= AXES) return;
      for (int k = 0; k < WINDOW - 1; k++) begin
         trace_store[ax][k] = trace_store[ax][k+1];
         trace_live[ax][k]  = trace_live[ax][k+1];
      end
      trace_store[ax][WINDOW-1] = item.sample;
      trace_live[ax][WINDOW-1]  = 1'b1;
      for (int k = 0; k < WINDOW; k++) begin
         if (trace_live[ax][k]) begin
            if (!seen || int'(trace_store[ax][k]) > hi) hi = int'(trace_store[ax][k]);
            if (!seen || int'(trace_store[ax][k]) < lo) lo = int'(trace_store[ax][k]);
            seen = 1'b1;
         end
      end
      span = int'(hi - lo);
      for (int k = 0; k < WINDOW - 1; k++) begin
         seg.column       = COLUMN_W'(k);
         seg.y_left       = ROW_W'(HEIGHT);
         seg.y_right      = ROW_W'(HEIGHT);
         seg.last_segment = (k == WINDOW - 2);
         if (span != 0 && trace_live[ax][k] && trace_live[ax][k+1]) begin
            seg.y_left  = scaled_row(int'(trace_store[ax][k]), hi, span);
            seg.y_right = scaled_row(int'(trace_store[ax][k+1]), hi, span);
         end
         expected_segments.push_back(seg);
      end
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2, 3: begin
            return SAMPLE_W'($urandom());
         end
         4, 5, 6: begin
            return SAMPLE_W'(1000 + int'($urandom_range(0, 6)) - 3);
         end
         7: begin
            return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         end
         default: begin
            return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
         end
      endcase
   endfunction

   task automatic send_sample(input logic [1:0] ax, input logic signed [SAMPLE_W-1:0] value);
      int                gap;
      rwat_pkg::req_type item;
      item.axis_select = ax;
      item.sample      = value;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while ((req_valid && req_ready) !== 1'b1);
      predict_segments(item);
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_segments.size() != 0);
   endtask

   task automatic test_startup_window;
      send_sample(2'd0, 16'sd0);
      send_sample(2'd0, 16'sd5);
      wait_drained();
   endtask

   task automatic test_sample_extremes;
      send_sample(2'd1, 16'sh8000);
      send_sample(2'd1, 16'sh7fff);
      send_sample(2'd1, 16'sd0);
      send_sample(2'd1, -16'sd1);
      send_sample(2'd1, 16'sd1);
      send_sample(2'd1, 16'sh8000);
      wait_drained();
   endtask

   task automatic test_flat_window;
      repeat (4) send_sample(2'd2, 16'sd1234);
      wait_drained();
   endtask

   task automatic test_unused_axis;
      send_sample(2'd3, 16'sh8000);
      send_sample(2'd3, 16'sh7fff);
      send_sample(2'd0, -16'sd7);
      send_sample(2'd3, -16'sd1);
      send_sample(2'd3, random_sample());
      send_sample(2'd0, 16'sd9);
      wait_drained();
   endtask

   task automatic test_window_rollover;
      no_idle = 1'b1;
      send_sample(2'd2, 16'sh7fff);
      repeat (WINDOW + 5) send_sample(2'd2, SAMPLE_W'(int'($urandom_range(0, 200)) - 100));
      wait_drained();
      no_idle = 1'b0;
   endtask

   task automatic test_stalled_output;
      hold_len = HOLD_CYCLES;
      repeat (4) send_sample(2'd1, random_sample());
      wait_drained();
   endtask

   task automatic test_random_traffic;
      int sent;
      sent = 0;
      while (sent < 130) begin
         if ($urandom_range(0, 9) == 0) begin
            send_sample(2'd3, random_sample());
         end else begin
            send_sample(2'($urandom_range(0, 2)), random_sample());
            sent++;
         end
      end
      wait_drained();
   endtask

   initial begin : hold_off
      hold_active <= 1'b0;
      forever begin
         wait (hold_len > 0);
         @(posedge clock);
         hold_active <= 1'b1;
         repeat (hold_len) @(posedge clock);
         hold_active <= 1'b0;
         hold_len = 0;
      end
   end

   initial begin : result_drain
      int                stall;
      rwat_pkg::rsp_type want;
      drain_ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            drain_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         drain_ready <= 1'b1;
         do @(posedge clock); while ((rsp_valid && rsp_ready) !== 1'b1);
         if (expected_segments.size() == 0) begin
            $error("unexpected transfer: column %0d y_left %0d y_right %0d",
                   rsp_data.column, rsp_data.y_left, rsp_data.y_right);
            error_count++;
         end else begin
            want = expected_segments.pop_front();
            if (rsp_data.column !== want.column) begin
               $error("column: expected %0d, actual %0d", want.column, rsp_data.column);
               error_count++;
            end
            if (rsp_data.y_left !== want.y_left) begin
               $error("y_left: expected %0d, actual %0d", want.y_left, rsp_data.y_left);
               error_count++;
            end
            if (rsp_data.y_right !== want.y_right) begin
               $error("y_right: expected %0d, actual %0d", want.y_right, rsp_data.y_right);
               error_count++;
            end
            if (rsp_data.last_segment !== want.last_segment) begin
               $error("last_segment: expected %0d, actual %0d",
                      want.last_segment, rsp_data.last_segment);
               error_count++;
            end
         end
      end
   end

   initial begin : timeout
      #(25_000_000);
      $display("rolling_window_autoscale_trace_top verification failed");
      $finish;
   end

   initial begin : main
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_startup_window();
      test_sample_extremes();
      test_flat_window();
      test_unused_axis();
      test_window_rollover();
      test_stalled_output();
      test_random_traffic();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("rolling_window_autoscale_trace_top verification clean");
      end else begin
         $display("rolling_window_autoscale_trace_top verification failed");
      end
      $finish;
   end

endmodule
